// ===== rtl/core/tcwc_pkg.sv =====
// Shared types, constants and the control store of the congestion window block.
// Used by tcwc_sequencer, tcwc_datapath and tcp_congestion_window_control.
package tcwc_pkg;

    localparam int PcW = 5;
    typedef logic [PcW-1:0] t_pc;

    // Event kinds carried in tuser.
    typedef logic [1:0] t_func;
    localparam t_func FUNC_EST     = 2'd0;
    localparam t_func FUNC_BURST   = 2'd1;
    localparam t_func FUNC_ACK     = 2'd2;
    localparam t_func FUNC_TIMEOUT = 2'd3;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAX_SEGMENT       = 2'd0;
    localparam t_cfg_idx CFG_INITIAL_WINDOW    = 2'd1;
    localparam t_cfg_idx CFG_INITIAL_THRESHOLD = 2'd2;

    localparam logic [15:0] RST_MAX_SEGMENT       = 16'd1400;
    localparam logic [31:0] RST_INITIAL_WINDOW    = 32'd1400;
    localparam logic [31:0] RST_INITIAL_THRESHOLD = 32'd65535;

    localparam logic [1:0] DUP_BEFORE_LIMIT = 2'd2;
    localparam logic [1:0] DUP_LIMIT        = 2'd3;

    // Datapath operations.
    typedef logic [3:0] t_op;
    localparam t_op OP_NOP     = 4'd0;
    localparam t_op OP_EST     = 4'd1;
    localparam t_op OP_BURST   = 4'd2;
    localparam t_op OP_CUT     = 4'd3;
    localparam t_op OP_CW_MSS  = 4'd4;
    localparam t_op OP_LASTWIN = 4'd5;
    localparam t_op OP_DUPINC  = 4'd6;
    localparam t_op OP_WIN     = 4'd7;
    localparam t_op OP_CW_TRI  = 4'd8;
    localparam t_op OP_NEWACK  = 4'd9;
    localparam t_op OP_DIVINIT = 4'd10;
    localparam t_op OP_DIVSTEP = 4'd11;
    localparam t_op OP_CA_GROW = 4'd12;
    localparam t_op OP_SS_GROW = 4'd13;
    localparam t_op OP_EMIT    = 4'd14;

    // Jump conditions.
    typedef logic [3:0] t_cond;
    localparam t_cond C_NONE      = 4'd0;
    localparam t_cond C_ALWAYS    = 4'd1;
    localparam t_cond C_NO_REQ    = 4'd2;
    localparam t_cond C_IS_EST    = 4'd3;
    localparam t_cond C_IS_BURST  = 4'd4;
    localparam t_cond C_IS_ACK    = 4'd5;
    localparam t_cond C_NOBURST   = 4'd6;
    localparam t_cond C_DUP       = 4'd7;
    localparam t_cond C_NEWACK    = 4'd8;
    localparam t_cond C_DUP2      = 4'd9;
    localparam t_cond C_SLOWSTART = 4'd10;
    localparam t_cond C_DIV_MORE  = 4'd11;
    localparam t_cond C_OUT_BUSY  = 4'd12;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic is_est;
        logic is_burst;
        logic is_ack;
        logic no_burst;
        logic dup;
        logic new_ack;
        logic dup2;
        logic slow_start;
        logic div_more;
    } t_flags;

    // Program labels.
    localparam t_pc PC_IDLE     = 5'd0;
    localparam t_pc PC_DISP_EST = 5'd1;
    localparam t_pc PC_DISP_BST = 5'd2;
    localparam t_pc PC_DISP_ACK = 5'd3;
    localparam t_pc PC_TO_CUT   = 5'd4;
    localparam t_pc PC_TO_CW    = 5'd5;
    localparam t_pc PC_EST      = 5'd6;
    localparam t_pc PC_BURST    = 5'd7;
    localparam t_pc PC_ACK      = 5'd8;
    localparam t_pc PC_ACK_DUP  = 5'd9;
    localparam t_pc PC_ACK_NEW  = 5'd10;
    localparam t_pc PC_LASTWIN  = 5'd11;
    localparam t_pc PC_DUPINC   = 5'd12;
    localparam t_pc PC_WIN      = 5'd13;
    localparam t_pc PC_TRI_CUT  = 5'd14;
    localparam t_pc PC_TRI_CW   = 5'd15;
    localparam t_pc PC_NEWACK   = 5'd16;
    localparam t_pc PC_DIVINIT  = 5'd17;
    localparam t_pc PC_DIVSTEP  = 5'd18;
    localparam t_pc PC_CA_GROW  = 5'd19;
    localparam t_pc PC_SS_GROW  = 5'd20;
    // The emit step sits at the top address so that falling through wraps to idle.
    localparam t_pc PC_EMIT     = 5'd31;

    function automatic t_uword ucode(input t_pc addr);
        t_uword w;
        case (addr)
            PC_IDLE:     w = '{OP_NOP,     C_NO_REQ,    PC_IDLE};
            PC_DISP_EST: w = '{OP_NOP,     C_IS_EST,    PC_EST};
            PC_DISP_BST: w = '{OP_NOP,     C_IS_BURST,  PC_BURST};
            PC_DISP_ACK: w = '{OP_NOP,     C_IS_ACK,    PC_ACK};
            PC_TO_CUT:   w = '{OP_CUT,     C_NONE,      PC_IDLE};
            PC_TO_CW:    w = '{OP_CW_MSS,  C_ALWAYS,    PC_EMIT};
            PC_EST:      w = '{OP_EST,     C_ALWAYS,    PC_EMIT};
            PC_BURST:    w = '{OP_BURST,   C_ALWAYS,    PC_EMIT};
            PC_ACK:      w = '{OP_NOP,     C_NOBURST,   PC_LASTWIN};
            PC_ACK_DUP:  w = '{OP_NOP,     C_DUP,       PC_DUPINC};
            PC_ACK_NEW:  w = '{OP_NOP,     C_NEWACK,    PC_NEWACK};
            PC_LASTWIN:  w = '{OP_LASTWIN, C_ALWAYS,    PC_EMIT};
            PC_DUPINC:   w = '{OP_DUPINC,  C_DUP2,      PC_TRI_CUT};
            PC_WIN:      w = '{OP_WIN,     C_ALWAYS,    PC_EMIT};
            PC_TRI_CUT:  w = '{OP_CUT,     C_NONE,      PC_IDLE};
            PC_TRI_CW:   w = '{OP_CW_TRI,  C_ALWAYS,    PC_EMIT};
            PC_NEWACK:   w = '{OP_NEWACK,  C_SLOWSTART, PC_SS_GROW};
            PC_DIVINIT:  w = '{OP_DIVINIT, C_NONE,      PC_IDLE};
            PC_DIVSTEP:  w = '{OP_DIVSTEP, C_DIV_MORE,  PC_DIVSTEP};
            PC_CA_GROW:  w = '{OP_CA_GROW, C_ALWAYS,    PC_EMIT};
            PC_SS_GROW:  w = '{OP_SS_GROW, C_ALWAYS,    PC_EMIT};
            PC_EMIT:     w = '{OP_EMIT,    C_OUT_BUSY,  PC_EMIT};
            default:     w = '{OP_NOP,     C_ALWAYS,    PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/tcwc_sequencer.sv =====
// Step counter and control store of the congestion window block.
// Depends on tcwc_pkg for the program, operation and condition codes.
module tcwc_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_out_busy,
    input  tcwc_pkg::t_flags i_flags,
    output tcwc_pkg::t_op    o_op,
    output logic             o_idle
);

    tcwc_pkg::t_pc    r_pc;
    tcwc_pkg::t_pc    n_pc;
    tcwc_pkg::t_uword w_uw;
    logic             w_take;

    assign w_uw   = tcwc_pkg::ucode(r_pc);
    assign o_op   = w_uw.op;
    assign o_idle = (r_pc == tcwc_pkg::PC_IDLE);

    always_comb begin
        case (w_uw.cond)
            tcwc_pkg::C_NONE:      w_take = 1'b0;
            tcwc_pkg::C_ALWAYS:    w_take = 1'b1;
            tcwc_pkg::C_NO_REQ:    w_take = !i_start;
            tcwc_pkg::C_IS_EST:    w_take = i_flags.is_est;
            tcwc_pkg::C_IS_BURST:  w_take = i_flags.is_burst;
            tcwc_pkg::C_IS_ACK:    w_take = i_flags.is_ack;
            tcwc_pkg::C_NOBURST:   w_take = i_flags.no_burst;
            tcwc_pkg::C_DUP:       w_take = i_flags.dup;
            tcwc_pkg::C_NEWACK:    w_take = i_flags.new_ack;
            tcwc_pkg::C_DUP2:      w_take = i_flags.dup2;
            tcwc_pkg::C_SLOWSTART: w_take = i_flags.slow_start;
            tcwc_pkg::C_DIV_MORE:  w_take = i_flags.div_more;
            tcwc_pkg::C_OUT_BUSY:  w_take = i_out_busy;
            default:               w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= tcwc_pkg::PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ===== rtl/core/tcwc_datapath.sv =====
// Congestion state registers, sequence compares and the one-bit-per-step divider.
// Depends on tcwc_pkg; driven one operation per cycle by tcwc_sequencer.
module tcwc_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [1:0]       i_func,
    input  logic [31:0]      i_first_seq,
    input  logic [15:0]      i_burst_len,
    input  logic [31:0]      i_ack_num,
    input  logic [15:0]      i_peer_win,
    input  tcwc_pkg::t_op    i_op,
    input  logic [15:0]      i_max_segment,
    input  logic [31:0]      i_initial_window,
    input  logic [31:0]      i_initial_threshold,
    output tcwc_pkg::t_flags o_flags,
    output logic [31:0]      o_cong_window,
    output logic [31:0]      o_slow_threshold,
    output logic [15:0]      o_send_allowance,
    output logic [31:0]      o_resume_seq,
    output logic             o_burst_done,
    output logic             o_retransmit
);

    logic [1:0]  r_func;
    logic [31:0] r_first_seq;
    logic [15:0] r_burst_len;
    logic [31:0] r_ack;
    logic [15:0] r_peer_win;

    logic [31:0] r_cwnd, n_cwnd;
    logic [31:0] r_ss, n_ss;
    logic [15:0] r_pw, n_pw;
    logic [31:0] r_acked, n_acked;
    logic [31:0] r_last, n_last;
    logic [31:0] r_end, n_end;
    logic [1:0]  r_dup, n_dup;
    logic        r_retx, n_retx;
    logic [31:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_div, n_div;
    logic [4:0]  r_cnt, n_cnt;

    logic [31:0] w_mss;
    logic [31:0] w_half;
    logic [31:0] w_cut;
    logic [32:0] w_ss_inc;
    logic [31:0] w_ss_sat;
    logic [31:0] w_grow_step;
    logic [32:0] w_sum;
    logic [31:0] w_grow;
    logic [31:0] w_d_acked;
    logic [31:0] w_d_end;
    logic        w_new_ack;
    logic        w_after_end;
    logic [31:0] w_sq;
    logic [32:0] w_rem_sh;
    logic        w_fits;

    assign w_mss       = {16'd0, i_max_segment};
    assign w_half      = {1'b0, r_cwnd[31:1]};
    assign w_cut       = (w_half < w_mss) ? w_mss : w_half;
    assign w_ss_inc    = {1'b0, r_ss} + 33'd1;
    assign w_ss_sat    = w_ss_inc[32] ? 32'hFFFF_FFFF : w_ss_inc[31:0];
    assign w_grow_step = (i_op == tcwc_pkg::OP_SS_GROW) ? w_mss : r_q;
    assign w_sum       = {1'b0, r_cwnd} + {1'b0, w_grow_step};
    assign w_grow      = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_d_acked   = r_ack - r_acked;
    assign w_d_end     = r_ack - r_end;
    assign w_new_ack   = (w_d_acked != 32'd0) && !w_d_acked[31];
    assign w_after_end = (w_d_end != 32'd0) && !w_d_end[31];
    assign w_sq        = w_mss * w_mss;
    assign w_rem_sh    = {r_rem[31:0], r_q[31]};
    assign w_fits      = (w_rem_sh >= {1'b0, r_div});

    always_comb begin
        n_cwnd  = r_cwnd;
        n_ss    = r_ss;
        n_pw    = r_pw;
        n_acked = r_acked;
        n_last  = r_last;
        n_end   = r_end;
        n_dup   = r_dup;
        n_retx  = r_retx;
        n_q     = r_q;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cnt   = r_cnt;
        if (i_load) begin
            n_retx = 1'b0;
        end
        case (i_op)
            tcwc_pkg::OP_EST: begin
                n_cwnd = i_initial_window;
                n_ss   = i_initial_threshold;
                n_pw   = r_peer_win;
                n_dup  = 2'd0;
            end
            tcwc_pkg::OP_BURST: begin
                n_acked = r_first_seq;
                n_last  = r_first_seq;
                n_end   = r_first_seq + {16'd0, r_burst_len};
                n_dup   = 2'd0;
            end
            tcwc_pkg::OP_CUT: begin
                n_ss   = w_cut;
                n_retx = 1'b1;
            end
            tcwc_pkg::OP_CW_MSS: begin
                n_cwnd = w_mss;
                n_dup  = 2'd0;
            end
            tcwc_pkg::OP_LASTWIN: begin
                n_last = r_ack;
                n_pw   = r_peer_win;
            end
            tcwc_pkg::OP_DUPINC: begin
                n_dup = r_dup + 2'd1;
            end
            tcwc_pkg::OP_WIN: begin
                n_pw = r_peer_win;
            end
            tcwc_pkg::OP_CW_TRI: begin
                n_cwnd = (w_ss_sat < w_mss) ? w_mss : w_ss_sat;
                n_dup  = 2'd0;
            end
            tcwc_pkg::OP_NEWACK: begin
                n_dup   = 2'd0;
                n_last  = r_ack;
                n_acked = w_after_end ? r_end : r_ack;
                n_pw    = r_peer_win;
            end
            tcwc_pkg::OP_DIVINIT: begin
                n_q   = w_sq;
                n_rem = 33'd0;
                n_div = (r_cwnd == 32'd0) ? 32'd1 : r_cwnd;
                n_cnt = '1;
            end
            tcwc_pkg::OP_DIVSTEP: begin
                n_q   = {r_q[30:0], w_fits};
                n_rem = w_fits ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
                n_cnt = r_cnt - 5'd1;
            end
            tcwc_pkg::OP_CA_GROW,
            tcwc_pkg::OP_SS_GROW: begin
                n_cwnd = w_grow;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_func      <= i_func;
            r_first_seq <= i_first_seq;
            r_burst_len <= i_burst_len;
            r_ack       <= i_ack_num;
            r_peer_win  <= i_peer_win;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
        r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd  <= tcwc_pkg::RST_INITIAL_WINDOW;
            r_ss    <= tcwc_pkg::RST_INITIAL_THRESHOLD;
            r_pw    <= 16'd0;
            r_acked <= 32'd0;
            r_last  <= 32'd0;
            r_end   <= 32'd0;
            r_dup   <= 2'd0;
            r_retx  <= 1'b0;
        end else begin
            r_cwnd  <= n_cwnd;
            r_ss    <= n_ss;
            r_pw    <= n_pw;
            r_acked <= n_acked;
            r_last  <= n_last;
            r_end   <= n_end;
            r_dup   <= n_dup;
            r_retx  <= n_retx;
        end
    end

    assign o_flags.is_est     = (r_func == tcwc_pkg::FUNC_EST);
    assign o_flags.is_burst   = (r_func == tcwc_pkg::FUNC_BURST);
    assign o_flags.is_ack     = (r_func == tcwc_pkg::FUNC_ACK);
    assign o_flags.no_burst   = (r_acked == r_end);
    assign o_flags.dup        = (r_ack == r_last);
    assign o_flags.new_ack    = w_new_ack;
    assign o_flags.dup2       = (r_dup == tcwc_pkg::DUP_BEFORE_LIMIT);
    assign o_flags.slow_start = (r_cwnd < r_ss);
    assign o_flags.div_more   = (r_cnt != 5'd0);

    assign o_cong_window    = r_cwnd;
    assign o_slow_threshold = r_ss;
    assign o_send_allowance = ({16'd0, r_pw} < r_cwnd) ? r_pw : r_cwnd[15:0];
    assign o_resume_seq     = r_acked;
    assign o_burst_done     = (r_acked == r_end);
    assign o_retransmit     = r_retx;

    // The duplicate count never rests at the limit once a result is being sent.
    a_dup_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == tcwc_pkg::OP_EMIT) |-> (r_dup != tcwc_pkg::DUP_LIMIT))
        else $error("duplicate ack count left at limit");

    // A divide always ends with the growth step.
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_op == tcwc_pkg::OP_DIVSTEP) && (r_cnt == 5'd0))
            |=> (i_op == tcwc_pkg::OP_CA_GROW))
        else $error("divider did not hand over to window growth");

endmodule

// ===== rtl/core/tcp_congestion_window_control.sv =====
// Top level of the sender-side congestion window and ack tracker.
// Depends on tcwc_pkg, tcwc_sequencer and tcwc_datapath.
//
// Usage:
//   Requests enter on the slave stream: tuser holds the event kind (established,
//   burst start, ack received, ack timeout) and tdata the sequence, length, ack
//   and window fields. Every request yields exactly one result on the master
//   stream with the window, threshold, send allowance, resume point and flags.
//   Configuration registers are written through the plain write port; the user must
//   write them only while the block is idle, which the block itself does not enforce.
//   A request runs through the dispatch steps, the update steps for its kind and the
//   emit step; an ack in congestion avoidance also runs through the 32 one-bit steps
//   of the divider. The sequencer takes one request at a time and is ready again
//   once the result is loaded into the output register.
//   A result waiting in the output register does not block the next request; if
//   the receiver stalls, the second result is held at the final step until the
//   output register frees.
//   Reset loads the default configuration, the initial window and threshold and
//   clears all sequence state; the block is ready as soon as reset is released.
module tcp_congestion_window_control (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    // first_seq[31:0], burst_len[47:32], ack_num[79:48], peer_win[95:80]
    input  logic [95:0]   i_s_axis_tdata,
    // func[1:0]
    input  logic [1:0]    i_s_axis_tuser,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // cong_window[31:0], slow_threshold[63:32], send_allowance[79:64],
    // resume_seq[111:80], burst_done[112], retransmit[113], zero[119:114]
    output logic [119:0]  o_m_axis_tdata,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_addr,
    input  logic [31:0]   i_cfg_wdata
);

    logic [15:0]      r_max_segment;
    logic [31:0]      r_initial_window;
    logic [31:0]      r_initial_threshold;
    logic             r_m_valid;
    logic [119:0]     r_m_data;

    logic             w_accept;
    logic             w_idle;
    logic             w_out_busy;
    logic             w_out_load;
    tcwc_pkg::t_op    w_op;
    tcwc_pkg::t_flags w_flags;
    logic [31:0]      w_cwnd;
    logic [31:0]      w_ss;
    logic [15:0]      w_allow;
    logic [31:0]      w_resume;
    logic             w_done;
    logic             w_retx;

    assign o_s_axis_tready = w_idle;
    assign w_accept        = i_s_axis_tvalid && w_idle;
    assign w_out_busy      = r_m_valid && !i_m_axis_tready;
    assign w_out_load      = (w_op == tcwc_pkg::OP_EMIT) && !w_out_busy;

    tcwc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_out_busy (w_out_busy),
        .i_flags    (w_flags),
        .o_op       (w_op),
        .o_idle     (w_idle)
    );

    tcwc_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (w_accept),
        .i_func              (i_s_axis_tuser),
        .i_first_seq         (i_s_axis_tdata[31:0]),
        .i_burst_len         (i_s_axis_tdata[47:32]),
        .i_ack_num           (i_s_axis_tdata[79:48]),
        .i_peer_win          (i_s_axis_tdata[95:80]),
        .i_op                (w_op),
        .i_max_segment       (r_max_segment),
        .i_initial_window    (r_initial_window),
        .i_initial_threshold (r_initial_threshold),
        .o_flags             (w_flags),
        .o_cong_window       (w_cwnd),
        .o_slow_threshold    (w_ss),
        .o_send_allowance    (w_allow),
        .o_resume_seq        (w_resume),
        .o_burst_done        (w_done),
        .o_retransmit        (w_retx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_segment       <= tcwc_pkg::RST_MAX_SEGMENT;
            r_initial_window    <= tcwc_pkg::RST_INITIAL_WINDOW;
            r_initial_threshold <= tcwc_pkg::RST_INITIAL_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                tcwc_pkg::CFG_MAX_SEGMENT:       r_max_segment       <= i_cfg_wdata[15:0];
                tcwc_pkg::CFG_INITIAL_WINDOW:    r_initial_window    <= i_cfg_wdata;
                tcwc_pkg::CFG_INITIAL_THRESHOLD: r_initial_threshold <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_data <= {6'd0, w_retx, w_done, w_resume, w_allow, w_ss, w_cwnd};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_axis_tready)
        else $error("sequencer stayed idle after a request");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_op == tcwc_pkg::OP_EMIT))
        else $error("result appeared outside the emit step");

endmodule

// ===== tb/tcwc_checker.sv =====
// Checker for tcp_congestion_window_control: watches the request, report and write ports,
// predicts every window report and compares it field by field with what the block returns.
// Depends on tcwc_pkg for event kinds, register indexes and reset values.
module tcwc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    // first_seq[31:0], burst_len[47:32], ack_num[79:48], peer_win[95:80]
    input  logic [95:0]         i_req_data,
    // func[1:0]
    input  tcwc_pkg::t_func     i_req_kind,
    input  logic                i_rsp_valid,
    input  logic                i_rsp_ready,
    // cong_window[31:0], slow_threshold[63:32], send_allowance[79:64],
    // resume_seq[111:80], burst_done[112], retransmit[113], zero[119:114]
    input  logic [119:0]        i_rsp_data,
    input  logic                i_cfg_wr_en,
    input  tcwc_pkg::t_cfg_idx  i_cfg_addr,
    input  logic [31:0]         i_cfg_wdata,
    output int                  o_outstanding = 0,
    output int                  o_mismatches = 0,
    output int                  o_reports = 0,
    output int                  o_retransmits = 0
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  zero;
        logic        retransmit;
        logic        burst_done;
        logic [31:0] resume_seq;
        logic [15:0] send_allowance;
        logic [31:0] slow_threshold;
        logic [31:0] cong_window;
    } t_window_report;

    logic [15:0] seg_size;
    logic [31:0] init_window;
    logic [31:0] init_threshold;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [15:0] peer_window;
    logic [31:0] acked_point;
    logic [31:0] last_ack;
    logic [31:0] burst_end;
    logic [1:0]  dup_count;

    t_window_report reports_due[$];

    function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] diff;
        diff = a - b;
        return (diff != 32'd0) && !diff[31];
    endfunction

    function automatic logic [31:0] grow_saturated(input logic [31:0] a, input logic [63:0] b);
        logic [63:0] sum;
        sum = {32'd0, a} + b;
        return (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic logic [31:0] cut_threshold(input logic [31:0] window,
                                                  input logic [15:0] seg);
        return ((window >> 1) < {16'd0, seg}) ? {16'd0, seg} : (window >> 1);
    endfunction

    function automatic t_window_report predict_report(input tcwc_pkg::t_func kind,
                                                      input logic [95:0] fields);
        t_window_report r;
        logic [31:0] first_seq;
        logic [15:0] burst_len;
        logic [31:0] ack_num;
        logic [15:0] peer_win;
        logic        take_window;
        logic [63:0] ca_step;
        first_seq = fields[31:0];
        burst_len = fields[47:32];
        ack_num   = fields[79:48];
        peer_win  = fields[95:80];
        r = '0;
        case (kind)
            tcwc_pkg::FUNC_EST: begin
                cwnd        = init_window;
                ssthresh    = init_threshold;
                peer_window = peer_win;
                dup_count   = 2'd0;
            end
            tcwc_pkg::FUNC_BURST: begin
                acked_point = first_seq;
                last_ack    = first_seq;
                burst_end   = first_seq + {16'd0, burst_len};
                dup_count   = 2'd0;
            end
            tcwc_pkg::FUNC_ACK: begin
                take_window = 1'b1;
                if (acked_point == burst_end) begin
                    last_ack = ack_num;
                end else if (ack_num == last_ack) begin
                    dup_count = dup_count + 2'd1;
                    if (dup_count == tcwc_pkg::DUP_LIMIT) begin
                        ssthresh = cut_threshold(cwnd, seg_size);
                        cwnd = grow_saturated(ssthresh, 64'd1);
                        if (cwnd < {16'd0, seg_size}) begin
                            cwnd = {16'd0, seg_size};
                        end
                        dup_count    = 2'd0;
                        r.retransmit = 1'b1;
                        take_window  = 1'b0;
                    end
                end else if (seq_after(ack_num, acked_point)) begin
                    dup_count   = 2'd0;
                    last_ack    = ack_num;
                    acked_point = seq_after(ack_num, burst_end) ? burst_end : ack_num;
                    if (cwnd < ssthresh) begin
                        cwnd = grow_saturated(cwnd, {48'd0, seg_size});
                    end else begin
                        ca_step = ({48'd0, seg_size} * {48'd0, seg_size})
                                / ((cwnd == 32'd0) ? 64'd1 : {32'd0, cwnd});
                        cwnd = grow_saturated(cwnd, ca_step);
                    end
                end else begin
                    last_ack = ack_num;
                end
                if (take_window) begin
                    peer_window = peer_win;
                end
            end
            tcwc_pkg::FUNC_TIMEOUT: begin
                ssthresh     = cut_threshold(cwnd, seg_size);
                cwnd         = {16'd0, seg_size};
                dup_count    = 2'd0;
                r.retransmit = 1'b1;
            end
            default: begin
            end
        endcase
        r.cong_window    = cwnd;
        r.slow_threshold = ssthresh;
        r.send_allowance = ({16'd0, peer_window} < cwnd) ? peer_window : cwnd[15:0];
        r.resume_seq     = acked_point;
        r.burst_done     = (acked_point == burst_end);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_mismatches++;
        $display("[%0t] mismatch at report %0d, %s: got %h, expected %h",
                 $time, o_reports, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_window_report want;
        t_window_report got;
        if (!i_rst_n) begin
            seg_size       = tcwc_pkg::RST_MAX_SEGMENT;
            init_window    = tcwc_pkg::RST_INITIAL_WINDOW;
            init_threshold = tcwc_pkg::RST_INITIAL_THRESHOLD;
            cwnd           = tcwc_pkg::RST_INITIAL_WINDOW;
            ssthresh       = tcwc_pkg::RST_INITIAL_THRESHOLD;
            peer_window    = 16'd0;
            acked_point    = 32'd0;
            last_ack       = 32'd0;
            burst_end      = 32'd0;
            dup_count      = 2'd0;
            reports_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    tcwc_pkg::CFG_MAX_SEGMENT:       seg_size = i_cfg_wdata[15:0];
                    tcwc_pkg::CFG_INITIAL_WINDOW:    init_window = i_cfg_wdata;
                    tcwc_pkg::CFG_INITIAL_THRESHOLD: init_threshold = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                reports_due.push_back(predict_report(i_req_kind, i_req_data));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got = i_rsp_data;
                if (reports_due.size() == 0) begin
                    report_mismatch("report with no request pending", got.cong_window, 32'd0);
                end else begin
                    want = reports_due.pop_front();
                    if (got.cong_window !== want.cong_window)
                        report_mismatch("cong_window", got.cong_window, want.cong_window);
                    if (got.slow_threshold !== want.slow_threshold)
                        report_mismatch("slow_threshold", got.slow_threshold,
                                        want.slow_threshold);
                    if (got.send_allowance !== want.send_allowance)
                        report_mismatch("send_allowance", {16'd0, got.send_allowance},
                                        {16'd0, want.send_allowance});
                    if (got.resume_seq !== want.resume_seq)
                        report_mismatch("resume_seq", got.resume_seq, want.resume_seq);
                    if (got.burst_done !== want.burst_done)
                        report_mismatch("burst_done", {31'd0, got.burst_done},
                                        {31'd0, want.burst_done});
                    if (got.retransmit !== want.retransmit)
                        report_mismatch("retransmit", {31'd0, got.retransmit},
                                        {31'd0, want.retransmit});
                    if (got.zero !== want.zero)
                        report_mismatch("padding bits", {26'd0, got.zero}, {26'd0, want.zero});
                    if (want.retransmit) begin
                        o_retransmits++;
                    end
                    o_reports++;
                end
            end
        end
        o_outstanding <= reports_due.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the congestion window testbench: clock, reset, request and write stimulus,
// report-side back-pressure, a no-progress watchdog and the final verdict.
// Depends on tcwc_pkg, tcp_congestion_window_control and tcwc_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETTINGS      = 8;
    localparam int ITEMS_PER_SETTING = 125;
    localparam int PRESSURE_SETTING  = 3;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES      = 60;
    localparam int WATCHDOG_LIMIT    = 2000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [95:0]        req_data = '0;
    tcwc_pkg::t_func    req_kind = tcwc_pkg::FUNC_EST;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic [119:0]       rsp_data;
    logic               cfg_wr_en = 1'b0;
    tcwc_pkg::t_cfg_idx cfg_addr = tcwc_pkg::CFG_MAX_SEGMENT;
    logic [31:0]        cfg_wdata = '0;

    int outstanding;
    int mismatches;
    int reports;
    int retransmits;
    int requests_sent = 0;
    int hold_asks = 0;
    bit sender_eager = 1'b0;

    tcp_congestion_window_control DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .i_s_axis_tuser  (req_kind),
        .o_m_axis_tvalid (rsp_valid),
        .i_m_axis_tready (rsp_ready),
        .o_m_axis_tdata  (rsp_data),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    tcwc_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req_data    (req_data),
        .i_req_kind    (req_kind),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp_data    (rsp_data),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches),
        .o_reports     (reports),
        .o_retransmits (retransmits)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_window();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 16'd0;
        if (roll == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic send_request(input tcwc_pkg::t_func kind, input logic [31:0] first_seq,
                                input logic [15:0] burst_len, input logic [31:0] ack_num,
                                input logic [15:0] peer_win);
        int gap;
        gap = sender_eager ? 0 : pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_kind  <= kind;
        req_data  <= {peer_win, ack_num, burst_len, first_seq};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        requests_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_register(input tcwc_pkg::t_cfg_idx idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // A connection exchange: optional establish, a burst, then a mix of acks and losses.
    task automatic run_exchange();
        logic [31:0] base;
        logic [31:0] acked;
        logic [31:0] last;
        logic [15:0] len;
        int          n_acks;
        int          roll;
        if ($urandom_range(0, 3) == 0) begin
            send_request(tcwc_pkg::FUNC_EST, $urandom, 16'($urandom), $urandom,
                         pick_window());
        end
        base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 70000)
                                           : $urandom;
        roll = $urandom_range(0, 19);
        len  = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF : 16'($urandom_range(1, 20000));
        send_request(tcwc_pkg::FUNC_BURST, base, len, $urandom, 16'($urandom));
        acked  = base;
        last   = base;
        n_acks = $urandom_range(3, 14);
        repeat (n_acks) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                acked = acked + $urandom_range(1, 6000);
                last  = acked;
                send_request(tcwc_pkg::FUNC_ACK, $urandom, 16'($urandom), last, pick_window());
            end else if (roll < 70) begin
                repeat ($urandom_range(1, 4))
                    send_request(tcwc_pkg::FUNC_ACK, $urandom, 16'($urandom), last,
                                 pick_window());
            end else if (roll < 80) begin
                last = acked - $urandom_range(1, 5000);
                send_request(tcwc_pkg::FUNC_ACK, $urandom, 16'($urandom), last, pick_window());
            end else if (roll < 87) begin
                send_request(tcwc_pkg::FUNC_TIMEOUT, $urandom, 16'($urandom), $urandom,
                             16'($urandom));
            end else if (roll < 92) begin
                last = acked + 32'h8000_0000 - $urandom_range(0, 2) + $urandom_range(0, 2);
                send_request(tcwc_pkg::FUNC_ACK, $urandom, 16'($urandom), last, pick_window());
            end else begin
                send_request(tcwc_pkg::t_func'($urandom), $urandom, 16'($urandom), $urandom,
                             16'($urandom));
            end
        end
    endtask

    initial begin
        int hold_served;
        int gap;
        hold_served = 0;
        forever begin
            if (hold_asks != hold_served) begin
                hold_served++;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    rsp_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                rsp_ready <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_wr_en || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no request or report moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int phase;
        int phase_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(tcwc_pkg::FUNC_ACK, '1, '1, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(tcwc_pkg::FUNC_TIMEOUT, '1, '1, '1, '1);
        send_request(tcwc_pkg::FUNC_EST, '1, '1, '1, 16'hFFFF);
        send_request(tcwc_pkg::FUNC_BURST, 32'hFFFF_FF00, 16'hFFFF, '0, '0);
        send_request(tcwc_pkg::FUNC_ACK, '0, '0, 32'h0000_02E8, 16'd1234);
        repeat (4) send_request(tcwc_pkg::FUNC_ACK, '0, '0, 32'h0000_02E8, 16'd777);
        send_request(tcwc_pkg::FUNC_ACK, '0, '0, 32'hFFFF_FEFB, 16'd5000);
        send_request(tcwc_pkg::FUNC_ACK, '0, '0, 32'hFFFF_FF00 + 32'h7FFF_FFFF, 16'd9000);
        send_request(tcwc_pkg::FUNC_ACK, '0, '0, '0, '0);
        send_request(tcwc_pkg::FUNC_BURST, '0, '0, '1, '1);
        send_request(tcwc_pkg::FUNC_ACK, '0, '0, '0, '0);
        send_request(tcwc_pkg::FUNC_BURST, 32'h1234_5678, 16'd3000, '0, '0);
        send_request(tcwc_pkg::FUNC_ACK, '0, '0, 32'h1234_5678 + 32'h8000_0000, 16'd100);
        send_request(tcwc_pkg::FUNC_TIMEOUT, '0, '0, '0, '0);
        send_request(tcwc_pkg::FUNC_EST, '0, '0, '0, 16'd0);
        send_request(tcwc_pkg::FUNC_ACK, '0, '0, 32'h1234_5678 + 32'd3000, 16'd2000);
        send_request(tcwc_pkg::FUNC_BURST, 32'hFFFF_FFFF, 16'd1, '0, '0);
        send_request(tcwc_pkg::FUNC_ACK, '0, '0, 32'd0, 16'h8000);
        send_request(tcwc_pkg::FUNC_EST, '0, '0, '0, 16'h8000);

        for (phase = 0; phase < NUM_SETTINGS; phase++) begin
            wait_drained();
            case (phase)
                0: ;
                1: begin
                    write_register(tcwc_pkg::CFG_MAX_SEGMENT, 32'd1);
                    write_register(tcwc_pkg::CFG_INITIAL_WINDOW, 32'd1);
                    write_register(tcwc_pkg::CFG_INITIAL_THRESHOLD, 32'd1);
                end
                2: begin
                    write_register(tcwc_pkg::CFG_MAX_SEGMENT, 32'd65535);
                    write_register(tcwc_pkg::CFG_INITIAL_WINDOW, 32'hFFFF_FFFF);
                    write_register(tcwc_pkg::CFG_INITIAL_THRESHOLD, 32'hFFFF_FFFF);
                end
                3: begin
                    write_register(tcwc_pkg::CFG_MAX_SEGMENT, 32'd65535);
                    write_register(tcwc_pkg::CFG_INITIAL_WINDOW, 32'hFFFF_FF00);
                    write_register(tcwc_pkg::CFG_INITIAL_THRESHOLD, 32'hFFFF_FFFF);
                end
                4: begin
                    write_register(tcwc_pkg::CFG_MAX_SEGMENT, 32'd536);
                    write_register(tcwc_pkg::CFG_INITIAL_WINDOW, 32'd2000);
                    write_register(tcwc_pkg::CFG_INITIAL_THRESHOLD, 32'd4000);
                end
                5: begin
                    write_register(tcwc_pkg::CFG_MAX_SEGMENT, $urandom_range(1, 65535));
                    write_register(tcwc_pkg::CFG_INITIAL_WINDOW, $urandom_range(1, 200000));
                    write_register(tcwc_pkg::CFG_INITIAL_THRESHOLD, $urandom_range(1, 200000));
                end
                6: begin
                    write_register(tcwc_pkg::CFG_MAX_SEGMENT, $urandom_range(1, 65535));
                    write_register(tcwc_pkg::CFG_INITIAL_WINDOW,
                                   $urandom_range(1, 32'hFFFF_FFFF));
                    write_register(tcwc_pkg::CFG_INITIAL_THRESHOLD,
                                   $urandom_range(1, 32'hFFFF_FFFF));
                end
                default: begin
                    write_register(tcwc_pkg::CFG_MAX_SEGMENT, $urandom_range(1, 64));
                    write_register(tcwc_pkg::CFG_INITIAL_WINDOW, $urandom_range(1, 5000));
                    write_register(tcwc_pkg::CFG_INITIAL_THRESHOLD, $urandom_range(1, 5000));
                end
            endcase
            cfg_wr_en <= 1'b0;
            sender_eager = (phase == PRESSURE_SETTING) || (phase % 3 == 2);
            if (phase == PRESSURE_SETTING) begin
                hold_asks <= hold_asks + 1;
            end
            phase_start = requests_sent;
            while (requests_sent - phase_start < ITEMS_PER_SETTING) run_exchange();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over %0d window settings; checked %0d reports,",
                 requests_sent, NUM_SETTINGS, reports);
        $display("%0d of them retransmits, across sequence wrap, duplicate ack runs, %s",
                 retransmits, "timeouts, window saturation and a long report stall.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tcwc_pkg.sv
rtl/core/tcwc_sequencer.sv
rtl/core/tcwc_datapath.sv
rtl/core/tcp_congestion_window_control.sv
tb/tcwc_checker.sv
tb/tb.sv
